### src/assert_macros.svh
// Assertion macros used by the checker file of the presence table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PT_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("presence table check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("presence table check failed: next-cycle implication");

`endif

### src/pt_pkg.sv
// Shared types, constants and defaults of the presence table unit.
package pt_pkg;

   localparam int unsigned DEF_TABLE_ENTRIES = 32;
   localparam int unsigned DEF_ID_BYTES      = 4;
   localparam int unsigned DEF_TIME_BITS     = 48;

   localparam int unsigned NODE_ID_BITS  = 32;
   localparam int unsigned NOW_TIME_BITS = 48;
   localparam int unsigned MAX_AGE_BITS  = 32;
   localparam int unsigned SLOT_BITS     = 5;

   localparam int unsigned MS_TO_US      = 1000;
   localparam int unsigned MS_TO_US_BITS = 10;
   localparam int unsigned LIMIT_BITS    = MAX_AGE_BITS + MS_TO_US_BITS;

   localparam logic FUNC_TOUCH = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic                     func;
      logic [NODE_ID_BITS-1:0]  node_id;
      logic [NOW_TIME_BITS-1:0] now_time;
      logic [MAX_AGE_BITS-1:0]  age_limit_ms;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [SLOT_BITS-1:0] slot;
      logic                 evicted;
      logic                 seen_recently;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan_step;
      logic finish;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_rd;
   } status_type;

endpackage

### src/pt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/pt_ctrl.sv
// Controller state machine of the presence table unit.
module pt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pt_pkg::cmd_type     cmd,
   input  pt_pkg::status_type  status
);
   import pt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH,
      ST_RESULT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_free;

   // The result register can take a new beat when empty or being drained.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == ST_IDLE) && req_valid;
      cmd.scan_step = (state_ff == ST_SCAN);
      cmd.finish    = (state_ff == ST_FINISH);
      cmd.load_rsp  = (state_ff == ST_RESULT) && rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (status.last_rd) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               state_ff <= ST_RESULT;
            end
            ST_RESULT: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if ((state_ff == ST_RESULT) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### src/pt_dpath.sv
// Datapath of the presence table unit: entry RAM, valid bits, scan trackers, result.
module pt_dpath #(
   parameter int unsigned TABLE_ENTRIES = pt_pkg::DEF_TABLE_ENTRIES,
   parameter int unsigned ID_BYTES      = pt_pkg::DEF_ID_BYTES,
   parameter int unsigned TIME_BITS     = pt_pkg::DEF_TIME_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  pt_pkg::cmd_type     cmd,
   output pt_pkg::status_type  status,
   input  pt_pkg::req_type     req_data,
   output pt_pkg::rsp_type     rsp_data
);
   import pt_pkg::*;

   localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int unsigned IDW    = (8 * ID_BYTES < NODE_ID_BITS) ? 8 * ID_BYTES : NODE_ID_BITS;
   localparam int unsigned TW     = (TIME_BITS < NOW_TIME_BITS) ? TIME_BITS : NOW_TIME_BITS;
   localparam int unsigned DW     = IDW + TW;
   localparam int unsigned CMP_W  = (TW > LIMIT_BITS) ? TW : LIMIT_BITS;
   localparam int unsigned LAST_I = TABLE_ENTRIES - 1;

   logic [IDW-1:0]           item_id_ff;
   logic [TW-1:0]            now_ff;
   logic                     func_ff;
   logic [LIMIT_BITS-1:0]    limit_ff;

   logic [IDX_W-1:0]         rd_idx_ff;
   logic [IDX_W-1:0]         eval_idx_ff;
   logic                     eval_pend_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;

   logic                     hit_ff;
   logic [IDX_W-1:0]         hit_idx_ff;
   logic [TW-1:0]            hit_time_ff;
   logic                     free_ff;
   logic [IDX_W-1:0]         free_idx_ff;
   logic                     old_ff;
   logic [IDX_W-1:0]         old_idx_ff;
   logic [TW-1:0]            old_time_ff;
   logic [TW-1:0]            age_ff;
   rsp_type                  rsp_ff;

   logic [DW-1:0]            rd_data;
   logic [IDW-1:0]           ent_id;
   logic [TW-1:0]            ent_time;
   logic                     ent_valid;
   logic [IDX_W-1:0]         target_idx;
   logic                     is_touch;
   logic                     wr_en;

   assign ent_id     = rd_data[DW-1:TW];
   assign ent_time   = rd_data[TW-1:0];
   assign ent_valid  = valid_ff[eval_idx_ff];
   assign is_touch   = (func_ff == FUNC_TOUCH);
   assign target_idx = hit_ff ? hit_idx_ff : (free_ff ? free_idx_ff : old_idx_ff);
   assign wr_en      = cmd.finish && is_touch;

   assign status.last_rd = (rd_idx_ff == IDX_W'(LAST_I));

   pt_ram #(
      .WIDTH (DW),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (target_idx),
      .wr_data ({item_id_ff, now_ff}),
      .rd_en   (cmd.scan_step),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         eval_pend_ff <= 1'b0;
      end else begin
         eval_pend_ff <= cmd.scan_step;
         if (wr_en) begin
            valid_ff[target_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_id_ff <= IDW'(req_data.node_id);
         now_ff     <= TW'(req_data.now_time);
         func_ff    <= req_data.func;
         limit_ff   <= LIMIT_BITS'(req_data.age_limit_ms) * LIMIT_BITS'(MS_TO_US);
         rd_idx_ff  <= '0;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
         old_ff     <= 1'b0;
      end else begin
         if (cmd.scan_step) begin
            rd_idx_ff   <= rd_idx_ff + IDX_W'(1);
            eval_idx_ff <= rd_idx_ff;
         end
         if (eval_pend_ff) begin
            // First valid match wins.
            if (ent_valid && (ent_id == item_id_ff) && !hit_ff) begin
               hit_ff      <= 1'b1;
               hit_idx_ff  <= eval_idx_ff;
               hit_time_ff <= ent_time;
            end
            // Lowest free entry.
            if (!ent_valid && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= eval_idx_ff;
            end
            // Oldest valid entry; strict compare keeps the lowest index on ties.
            if (ent_valid && (!old_ff || (ent_time < old_time_ff))) begin
               old_ff      <= 1'b1;
               old_idx_ff  <= eval_idx_ff;
               old_time_ff <= ent_time;
            end
         end
      end

      if (cmd.finish) begin
         // Time running backwards counts as zero age.
         age_ff <= (now_ff >= hit_time_ff) ? (now_ff - hit_time_ff) : '0;
      end

      if (cmd.load_rsp) begin
         rsp_ff.found         <= hit_ff;
         rsp_ff.slot          <= (is_touch || hit_ff) ? SLOT_BITS'(target_idx) : '0;
         rsp_ff.evicted       <= is_touch && !hit_ff && !free_ff;
         rsp_ff.seen_recently <= !is_touch && hit_ff &&
                                 (CMP_W'(age_ff) <= CMP_W'(limit_ff));
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### src/presence_table_lru_unit.sv
// Top level of the presence table unit with least-recently-seen replacement.
//
// The unit keeps TABLE_ENTRIES neighbor entries, each an id, a last-seen time in
// microseconds and a valid mark; reset clears every valid mark. A touch beat
// refreshes the time of the first valid entry whose id matches, otherwise writes
// the id into the lowest free entry, otherwise overwrites the valid entry with the
// smallest time (lowest index on ties) and reports evicted. A query beat reports
// whether the id is present and whether its age is at most age_limit_ms * 1000
// microseconds; a stored time later than now_time counts as zero age. Only the low
// 8*ID_BYTES bits of node_id and the low TIME_BITS bits of now_time are used.
// Each item is accepted, then its entries are read by the serial scan of the entry
// RAM through its single read port, one entry per cycle, then the drain, update and
// result stages follow; a new item is taken only after the result stage has loaded
// the previous result into the output register. A stalled earlier result holds
// the unit in its result stage until that beat is taken.
// The result sits in an output register, so a new request beat is accepted while
// an earlier result beat is still stalled.
module presence_table_lru_unit #(
   parameter int unsigned TABLE_ENTRIES = pt_pkg::DEF_TABLE_ENTRIES,
   parameter int unsigned ID_BYTES      = pt_pkg::DEF_ID_BYTES,
   parameter int unsigned TIME_BITS     = pt_pkg::DEF_TIME_BITS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  pt_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output pt_pkg::rsp_type rsp_data
);
   import pt_pkg::*;

   // Commands and status joining the controller and the datapath.
   cmd_type    cmd;
   status_type status;

   // The controller sequences accept, scan, drain, update and result stages.
   pt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the entry RAM, the valid marks and the scan trackers.
   pt_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ID_BYTES      (ID_BYTES),
      .TIME_BITS     (TIME_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

### src/pt_checker.sv
// Port-level assertion checker of the presence table unit and its bind.
`include "assert_macros.svh"

module pt_checker (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input pt_pkg::rsp_type rsp_data
);
   import pt_pkg::*;

   // The unit works on one item at a time, so it is busy right after a request beat.
   `PT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // A stalled result beat stays put.
   `PT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // An eviction only happens on a touch miss.
   `PT_ASSERT_IMPLY(a_evict_is_miss, clock, reset, rsp_valid && rsp_data.evicted, !rsp_data.found && !rsp_data.seen_recently)

   // A recent sighting needs a present entry.
   `PT_ASSERT_IMPLY(a_recent_found, clock, reset, rsp_valid && rsp_data.seen_recently, rsp_data.found && !rsp_data.evicted)

endmodule

bind presence_table_lru_unit pt_checker u_pt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
